[hw/rtl/fast_atan2_approx_core_macros.svh]
// assertion macros shared by the atan2 approximation core
`ifndef FAST_ATAN2_APPROX_CORE_MACROS_SVH
`define FAST_ATAN2_APPROX_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FA2_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fa2 same-cycle check failed");
`define FA2_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fa2 next-cycle check failed");
`else
`define FA2_ASSERT_IMP(label, ante, cons)
`define FA2_ASSERT_NXT(label, ante, cons)
`endif

`endif

[hw/rtl/fa2_pkg.sv]
// shared constants, types and helpers for the atan2 approximation core
package fa2_pkg;

    localparam int IN_WIDTH_DEF   = 24;
    localparam int ANGLE_FRAC_DEF = 13;
    localparam int ANGLE_WIDTH    = 16;

    // ratio r is Q1.15, its magnitude takes one quotient bit more than the fraction
    localparam int R_FRAC  = 15;
    localparam int Q_WIDTH = R_FRAC + 1;
    localparam logic [Q_WIDTH-1:0] Q_LIMIT = {1'b1, {(Q_WIDTH-1){1'b0}}};

    localparam logic [63:0] QUARTER_PI_Q30       = 64'd843314857;
    localparam logic [63:0] THREE_QUARTER_PI_Q30 = 64'd2529944570;

    typedef struct packed {
        logic num_neg;
        logic y_neg;
        logic x_neg;
    } fa2_side_t;

    // round a Q2.30 constant half up to frac fraction bits
    function automatic logic [63:0] to_angle_q(input logic [63:0] q30, input int frac);
        logic [63:0] half;
        half = 64'd1 << (29 - frac);
        return (q30 + half) >> (30 - frac);
    endfunction

endpackage

[hw/rtl/fa2_prep.sv]
// front end: |y| plus one lsb, then numerator magnitude and denominator
module fa2_prep #(
    parameter int IN_WIDTH = fa2_pkg::IN_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [IN_WIDTH-1:0] y_value,
    input  logic signed [IN_WIDTH-1:0] x_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IN_WIDTH:0]          num_mag,
    output logic [IN_WIDTH:0]          den,
    output fa2_pkg::fa2_side_t         side
);

    localparam int DW = IN_WIDTH + 1;
    localparam int SW = IN_WIDTH + 2;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic                       s1_ready;
    logic                       s2_ready;
    logic [DW-1:0]              ay_reg;
    logic [DW-1:0]              ay_next;
    logic signed [IN_WIDTH-1:0] x_reg;
    logic                       y_neg_reg;
    logic [DW-1:0]              mag_reg;
    logic [DW-1:0]              mag_next;
    logic [DW-1:0]              den_reg;
    logic [DW-1:0]              den_next;
    fa2_pkg::fa2_side_t         side_reg;
    fa2_pkg::fa2_side_t         side_next;
    logic signed [SW-1:0]       xs;
    logic signed [SW-1:0]       as;
    logic signed [SW-1:0]       d1;
    logic signed [SW-1:0]       d2;
    logic signed [SW-1:0]       s1;
    logic signed [SW-1:0]       s2;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        if (y_value[IN_WIDTH-1])
        begin
            ay_next = {1'b0, ~y_value} + DW'(2);
        end
        else
        begin
            ay_next = {1'b0, y_value} + DW'(1);
        end
    end

    // both signs of each sum in parallel, picked by the sign of x and of the numerator
    assign xs = SW'(x_reg);
    assign as = $signed({1'b0, ay_reg});
    assign d1 = xs - as;
    assign d2 = as - xs;
    assign s1 = xs + as;
    assign s2 = ~xs - as + SW'(1);

    always_comb
    begin
        side_next.y_neg = y_neg_reg;
        side_next.x_neg = x_reg[IN_WIDTH-1];
        if (!x_reg[IN_WIDTH-1])
        begin
            side_next.num_neg = d1[SW-1];
            den_next          = s1[DW-1:0];
            mag_next          = d1[SW-1] ? d2[DW-1:0] : d1[DW-1:0];
        end
        else
        begin
            side_next.num_neg = s1[SW-1];
            den_next          = d2[DW-1:0];
            mag_next          = s1[SW-1] ? s2[DW-1:0] : s1[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            ay_reg    <= ay_next;
            x_reg     <= x_value;
            y_neg_reg <= y_value[IN_WIDTH-1];
        end
        if (s2_ready)
        begin
            mag_reg  <= mag_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign num_mag = mag_reg;
    assign den     = den_reg;
    assign side    = side_reg;

endmodule

[hw/rtl/fa2_div.sv]
// pipelined restoring divider, one quotient bit per stage
module fa2_div #(
    parameter int IN_WIDTH = fa2_pkg::IN_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [IN_WIDTH:0]            num_mag,
    input  logic [IN_WIDTH:0]            den,
    input  fa2_pkg::fa2_side_t           in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fa2_pkg::Q_WIDTH-1:0]  quot,
    output fa2_pkg::fa2_side_t           out_side
);

    localparam int DW    = IN_WIDTH + 1;
    localparam int QW    = fa2_pkg::Q_WIDTH;
    localparam int STEPS = fa2_pkg::Q_WIDTH;

    logic               valid_reg [STEPS];
    logic [DW-1:0]      rem_reg   [STEPS];
    logic [DW-1:0]      den_reg   [STEPS];
    logic [QW-1:0]      q_reg     [STEPS];
    fa2_pkg::fa2_side_t side_reg  [STEPS];
    logic               stage_ready [STEPS+1];

    assign stage_ready[STEPS] = out_ready;
    assign in_ready           = stage_ready[0];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic               valid_in;
        logic [DW-1:0]      rem_in;
        logic [DW-1:0]      den_in;
        logic [QW-1:0]      q_in;
        fa2_pkg::fa2_side_t side_in;
        logic [DW:0]        trial;
        logic [DW:0]        diff;
        logic               take;
        logic               valid_next;
        logic [DW-1:0]      rem_next;
        logic [QW-1:0]      q_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = num_mag;
            assign den_in   = den;
            assign q_in     = '0;
            assign side_in  = in_side;
            // numerator magnitude never exceeds the denominator, so no doubling here
            assign trial    = {1'b0, rem_in};
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign q_in     = q_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign trial    = {rem_in, 1'b0};
        end

        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        assign diff           = trial - {1'b0, den_in};
        assign take           = trial >= {1'b0, den_in};
        assign rem_next       = take ? diff[DW-1:0] : trial[DW-1:0];
        assign q_next         = {q_in[QW-2:0], take};
        assign valid_next     = stage_ready[k] ? valid_in : valid_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k])
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign quot      = q_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

[hw/rtl/fa2_post.sv]
// back end: signed ratio, pi/4 scaling, base offset and y sign
module fa2_post #(
    parameter int ANGLE_FRAC = fa2_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fa2_pkg::Q_WIDTH-1:0]     quot,
    input  fa2_pkg::fa2_side_t              in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fa2_pkg::ANGLE_WIDTH-1:0] angle
);

    localparam int QW = fa2_pkg::Q_WIDTH;
    localparam int RW = QW + 1;
    localparam int PW = ANGLE_FRAC + 1 + RW;
    localparam int AW = ANGLE_FRAC + 3;
    localparam int EW = (AW > fa2_pkg::ANGLE_WIDTH) ? AW : fa2_pkg::ANGLE_WIDTH;

    localparam logic [ANGLE_FRAC-1:0] C1_M =
        ANGLE_FRAC'(fa2_pkg::to_angle_q(fa2_pkg::QUARTER_PI_Q30, ANGLE_FRAC));
    localparam logic [EW-1:0] C1_E =
        EW'(fa2_pkg::to_angle_q(fa2_pkg::QUARTER_PI_Q30, ANGLE_FRAC));
    localparam logic [EW-1:0] C3_E =
        EW'(fa2_pkg::to_angle_q(fa2_pkg::THREE_QUARTER_PI_Q30, ANGLE_FRAC));

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic                 s3_valid_reg;
    logic                 s3_valid_next;
    logic                 s1_ready;
    logic                 s2_ready;
    logic                 s3_ready;
    logic signed [RW-1:0] r_reg;
    logic signed [RW-1:0] r_next;
    fa2_pkg::fa2_side_t   s1_side_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    fa2_pkg::fa2_side_t   s2_side_reg;
    logic signed [PW-1:0] shifted;
    logic signed [EW-1:0] term;
    logic signed [EW-1:0] base;
    logic signed [EW-1:0] angle_reg;
    logic signed [EW-1:0] angle_next;
    logic signed [RW-1:0] q_ext;

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s3_valid_reg;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    assign q_ext     = $signed({1'b0, quot});
    assign r_next    = in_side.num_neg ? -q_ext : q_ext;
    assign prod_next = $signed({1'b0, C1_M}) * r_reg;

    // arithmetic shift floors the scaled ratio
    assign shifted    = prod_reg >>> fa2_pkg::R_FRAC;
    assign term       = shifted[EW-1:0];
    assign base       = s2_side_reg.x_neg ? $signed(C3_E) : $signed(C1_E);
    assign angle_next = s2_side_reg.y_neg ? (term - base) : (base - term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            r_reg       <= r_next;
            s1_side_reg <= in_side;
        end
        if (s2_ready)
        begin
            prod_reg    <= prod_next;
            s2_side_reg <= s1_side_reg;
        end
        if (s3_ready)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg[fa2_pkg::ANGLE_WIDTH-1:0];

endmodule

[hw/rtl/fast_atan2_approx_core.sv]
// top level of the pipelined fixed-point atan2 approximation core
//
//  channel   signals                          direction  width
//  input     in_valid in_ready y_value x_value in        2 x IN_WIDTH signed
//  output    out_valid out_ready angle          out       16 signed, Q3.13 default
//
// one request per cycle sustained while the output is not held; register stages: 2 front, 16 divider, 3 back
// the 16 divider stages come from the quotient, one quotient bit per register stage
// reset clears only the stage valid bits
// every stage has its own ready, so bubbles close up while the output waits
// in_ready falls only when all 21 stages are full and the output is held
`include "fast_atan2_approx_core_macros.svh"

module fast_atan2_approx_core #(
    parameter int IN_WIDTH   = fa2_pkg::IN_WIDTH_DEF,
    parameter int ANGLE_FRAC = fa2_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [IN_WIDTH-1:0]      y_value,
    input  logic signed [IN_WIDTH-1:0]      x_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [fa2_pkg::ANGLE_WIDTH-1:0] angle
);

    logic                         prep_valid;
    logic                         prep_ready;
    logic [IN_WIDTH:0]            prep_mag;
    logic [IN_WIDTH:0]            prep_den;
    fa2_pkg::fa2_side_t           prep_side;
    logic                         div_valid;
    logic                         div_ready;
    logic [fa2_pkg::Q_WIDTH-1:0]  div_q;
    fa2_pkg::fa2_side_t           div_side;
    logic [fa2_pkg::ANGLE_WIDTH-1:0] angle_bits;

    fa2_prep #(
        .IN_WIDTH (IN_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .num_mag   (prep_mag),
        .den       (prep_den),
        .side      (prep_side)
    );

    fa2_div #(
        .IN_WIDTH (IN_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .num_mag   (prep_mag),
        .den       (prep_den),
        .in_side   (prep_side),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quot      (div_q),
        .out_side  (div_side)
    );

    fa2_post #(
        .ANGLE_FRAC (ANGLE_FRAC)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .quot      (div_q),
        .in_side   (div_side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle     (angle_bits)
    );

    assign angle = $signed(angle_bits);

    // back pressure reaches the input only from a held output
    `FA2_ASSERT_IMP(a_stall_from_output, !in_ready, out_valid && !out_ready)
    // ratio magnitude never goes past one
    `FA2_ASSERT_IMP(a_quot_bound, div_valid, div_q <= fa2_pkg::Q_LIMIT)
    // a stalled divider result holds its quotient
    `FA2_ASSERT_NXT(a_div_hold, div_valid && !div_ready, div_valid && $stable(div_q))

endmodule

[sim/fast_atan2_approx_checker.sv]
// request and result monitor with angle prediction for the atan2 approximation core
`timescale 1ns / 1ps

module fast_atan2_approx_checker #(
    parameter int IN_WIDTH   = fa2_pkg::IN_WIDTH_DEF,
    parameter int ANGLE_FRAC = fa2_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [IN_WIDTH-1:0]             y_value,
    input  logic signed [IN_WIDTH-1:0]             x_value,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [fa2_pkg::ANGLE_WIDTH-1:0] angle,
    output int                                     failures,
    output int                                     pending
);

    localparam longint ROUND_HALF   = longint'(1) <<< (29 - ANGLE_FRAC);
    localparam longint QUARTER_PI   =
        (longint'(fa2_pkg::QUARTER_PI_Q30) + ROUND_HALF) >>> (30 - ANGLE_FRAC);
    localparam longint THREE_QTR_PI =
        (longint'(fa2_pkg::THREE_QUARTER_PI_Q30) + ROUND_HALF) >>> (30 - ANGLE_FRAC);

    logic [fa2_pkg::ANGLE_WIDTH-1:0] expected_angles[$];

    function automatic logic [fa2_pkg::ANGLE_WIDTH-1:0] predict_angle(
        input logic signed [IN_WIDTH-1:0] y_in,
        input logic signed [IN_WIDTH-1:0] x_in
    );
        longint y;
        longint x;
        longint ay;
        longint num;
        longint den;
        longint base;
        longint ratio;
        longint angle_q;
        y  = y_in;
        x  = x_in;
        ay = (y < 0 ? -y : y) + 1;
        if (x >= 0)
        begin
            num  = x - ay;
            den  = x + ay;
            base = QUARTER_PI;
        end
        else
        begin
            num  = x + ay;
            den  = ay - x;
            base = THREE_QTR_PI;
        end
        // quotient truncates toward zero, product shift floors
        ratio   = (num * (longint'(1) <<< fa2_pkg::R_FRAC)) / den;
        angle_q = base - ((QUARTER_PI * ratio) >>> fa2_pkg::R_FRAC);
        if (y < 0)
            angle_q = -angle_q;
        return angle_q[fa2_pkg::ANGLE_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [fa2_pkg::ANGLE_WIDTH-1:0] want;
        int                              errs;
        if (!rst_n)
        begin
            expected_angles.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && in_ready)
                expected_angles.push_back(predict_angle(y_value, x_value));
            if (out_valid && out_ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $error("angle result with no request pending: actual %0d", angle);
                    errs++;
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (angle !== want)
                    begin
                        $error("angle mismatch: expected %0d, actual %0d",
                               $signed(want), angle);
                        errs++;
                    end
                end
            end
            failures <= failures + errs;
            pending  <= expected_angles.size();
        end
    end

endmodule

[sim/fast_atan2_approx_core_test.sv]
// stimulus, clocking and verdict for the atan2 approximation core
`timescale 1ns / 1ps

module fast_atan2_approx_core_test;

    localparam int  IN_W         = fa2_pkg::IN_WIDTH_DEF;
    localparam int  RANDOM_COUNT = 1550;
    localparam int  CYCLE_LIMIT  = 200000;

    localparam logic signed [IN_W-1:0] MAX_V = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] MIN_V = {1'b1, {(IN_W-1){1'b0}}};

    logic                                   clk       = 1'b0;
    logic                                   rst_n     = 1'b0;
    logic                                   in_valid  = 1'b0;
    logic                                   in_ready;
    logic signed [IN_W-1:0]                 y_value   = '0;
    logic signed [IN_W-1:0]                 x_value   = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [fa2_pkg::ANGLE_WIDTH-1:0] angle;
    logic                                   calm      = 1'b0;
    int                                     failures;
    int                                     pending;
    int                                     cycle     = 0;

    fast_atan2_approx_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle     (angle)
    );

    fast_atan2_approx_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle     (angle),
        .failures  (failures),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("[fast_atan2_approx_core] ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 19);
    end

    task automatic send_request(input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] x);
        in_valid <= 1'b1;
        y_value  <= y;
        x_value  <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic random_request();
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] m;
        int                     pick;
        pick = $urandom_range(99);
        m    = IN_W'($urandom);
        if (pick < 60)
        begin
            y = IN_W'($urandom);
            x = IN_W'($urandom);
        end
        else if (pick < 80)
        begin
            y = IN_W'($urandom_range(128) - 64);
            x = IN_W'($urandom_range(128) - 64);
        end
        else
        begin
            case ($urandom_range(3))
                0:       begin y = m;  x = m;  end
                1:       begin y = m;  x = -m; end
                2:       begin y = '0; x = m;  end
                default: begin y = m;  x = '0; end
            endcase
        end
        send_request(y, x);
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both zero, axes, corners, diagonals and small off-diagonal points
        send_request('0, '0);
        send_request(MAX_V, MAX_V);
        send_request(MIN_V, MIN_V);
        send_request(MIN_V, '0);
        send_request('0, MIN_V);
        send_request(MAX_V, '0);
        send_request('0, MAX_V);
        send_request(MIN_V, MAX_V);
        send_request(MAX_V, MIN_V);
        send_request(IN_W'(-1), '0);
        send_request('0, IN_W'(-1));
        send_request(IN_W'(1), '0);
        send_request('0, IN_W'(1));
        send_request(IN_W'(1), IN_W'(1));
        send_request(IN_W'(-1), IN_W'(-1));
        send_request(IN_W'(-1), IN_W'(1));
        send_request(IN_W'(1), IN_W'(-1));
        send_request(MIN_V, IN_W'(-1));
        send_request(MAX_V, IN_W'(1));
        send_request(IN_W'(5), IN_W'(-3));
        send_request(IN_W'(-5), IN_W'(-3));
        send_request(IN_W'(-5), IN_W'(3));
        send_request(IN_W'(1000), IN_W'(-1000));

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            calm <= (i >= 700 && i < 1000);
            random_request();
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("[fast_atan2_approx_core] OK");
        else
            $display("[fast_atan2_approx_core] ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/fa2_pkg.sv
hw/rtl/fa2_prep.sv
hw/rtl/fa2_div.sv
hw/rtl/fa2_post.sv
hw/rtl/fast_atan2_approx_core.sv
sim/fast_atan2_approx_checker.sv
sim/fast_atan2_approx_core_test.sv
